FILE: rtl/core/raycast_wall_column_setup_assert.svh
// Assertion macros for the wall column setup checker.
`ifndef RAYCAST_WALL_COLUMN_SETUP_ASSERT_SVH
`define RAYCAST_WALL_COLUMN_SETUP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RCWS_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RCWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rcws_pkg.sv
// Shared constants, cosine table and pipeline token types for the wall column setup.
package rcws_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int TILE_UNITS    = 64;   // power of two
  localparam int TEX_ROWS      = 64;

  localparam int COL_W    = $clog2(SCREEN_WIDTH);
  localparam int DIST_W   = 24;
  localparam int ANGLE_W  = 16;
  localparam int COORD_W  = 24;
  localparam int FRAC_W   = 8;      // Q16.8 map units
  localparam int PPD_W    = 12;
  localparam int COS_W    = 16;     // Q1.15, 32768 fits unsigned
  localparam int COS_SHIFT = 15;
  localparam int HEIGHT_W = 16;
  localparam int ROW_W    = $clog2(SCREEN_HEIGHT + 1);
  localparam int FACE_W   = 2;
  localparam int TCOL_W   = $clog2(TILE_UNITS);
  localparam int TEX_W    = 22;

  localparam logic [PPD_W-1:0] PPD_RESET = PPD_W'(554);

  // quarter-wave cosine: 33 knots, one per 512 angle units
  localparam int COS_FRAC_W = 9;
  localparam int COS_IDX_W  = 5;
  localparam int QUARTER    = 2 ** (COS_FRAC_W + COS_IDX_W);
  localparam logic [COS_W-1:0] COS_QUARTER [0:32] = '{
    16'd32768, 16'd32729, 16'd32610, 16'd32413, 16'd32138, 16'd31786, 16'd31357, 16'd30853,
    16'd30274, 16'd29622, 16'd28899, 16'd28106, 16'd27246, 16'd26320, 16'd25330, 16'd24279,
    16'd23170, 16'd22006, 16'd20788, 16'd19520, 16'd18205, 16'd16846, 16'd15447, 16'd14010,
    16'd12540, 16'd11039, 16'd9512,  16'd7962,  16'd6393,  16'd4808,  16'd3212,  16'd1608,
    16'd0
  };

  localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
  localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;
  localparam logic [FACE_W-1:0] FACE_EAST  = 2'd2;
  localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

  // height divider: TILE * ppd * 256 over perp, 16 bits plus a saturation bit
  localparam int HNUM_SCALE = TILE_UNITS * 256;
  localparam int HNUM_W     = $clog2((2 ** PPD_W - 1) * HNUM_SCALE + 1);
  localparam int HQ_W       = HEIGHT_W + 1;
  localparam int HPOS_W     = $clog2(HQ_W);
  localparam int HCMP_W     = DIST_W + HQ_W;

  localparam int HALF_ROWS  = SCREEN_HEIGHT / 2;
  localparam int DTOP_W     = HEIGHT_W - 1;

  // texture divider: TEX_ROWS << 16 and dtop * TEX_ROWS << 16 over height
  localparam longint TSTEP_NUM = longint'(TEX_ROWS) * 65536;
  localparam int TSTEP_W = $clog2(TSTEP_NUM + 1);
  localparam int TNUM_W  = $clog2(longint'(2 ** DTOP_W - 1) * TSTEP_NUM + 1);
  localparam int TQ_W    = TSTEP_W;
  localparam int TPOS_W  = $clog2(TQ_W);
  localparam int TCMP_W  = HEIGHT_W + TQ_W;

  localparam logic [TEX_W-1:0]    TEX_MAX    = '1;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [FACE_W-1:0] face;
    logic [TCOL_W-1:0] tcol;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [DIST_W-1:0] perp;
    logic [HNUM_W-1:0] rem;
    logic [HQ_W-1:0]   quo;
  } hdiv_tok_t;

  typedef struct packed {
    side_t               side;
    logic [HEIGHT_W-1:0] height;
    logic [ROW_W-1:0]    top;
    logic [ROW_W-1:0]    bottom;
    logic [TNUM_W-1:0]   rem_start;
    logic [TSTEP_W-1:0]  rem_step;
    logic [TQ_W-1:0]     quo_start;
    logic [TQ_W-1:0]     quo_step;
  } tdiv_tok_t;

endpackage

FILE: rtl/core/rcws_hdiv_cell.sv
// One restoring-division cell of the strip height divider (one quotient bit).
module rcws_hdiv_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rcws_pkg::HPOS_W-1:0]  bit_pos,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  rcws_pkg::hdiv_tok_t          up_tok,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output rcws_pkg::hdiv_tok_t          dn_tok
);

  logic                          vld_r;
  rcws_pkg::hdiv_tok_t           tok_r;
  rcws_pkg::hdiv_tok_t           tok_nxt;
  logic [rcws_pkg::HCMP_W-1:0]   rem_ext;
  logic [rcws_pkg::HCMP_W-1:0]   sub_ext;

  always_comb begin
    rem_ext = rcws_pkg::HCMP_W'(up_tok.rem);
    sub_ext = rcws_pkg::HCMP_W'(up_tok.perp) << bit_pos;
    tok_nxt = up_tok;
    if (rem_ext >= sub_ext) begin
      tok_nxt.rem = up_tok.rem - rcws_pkg::HNUM_W'(sub_ext);
      tok_nxt.quo = up_tok.quo | (rcws_pkg::HQ_W'(1) << bit_pos);
    end
  end

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

FILE: rtl/core/rcws_tdiv_cell.sv
// One restoring-division cell of the texture divider: a quotient bit for start and step.
module rcws_tdiv_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rcws_pkg::TPOS_W-1:0]  bit_pos,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  rcws_pkg::tdiv_tok_t          up_tok,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output rcws_pkg::tdiv_tok_t          dn_tok
);

  logic                          vld_r;
  rcws_pkg::tdiv_tok_t           tok_r;
  rcws_pkg::tdiv_tok_t           tok_nxt;
  logic [rcws_pkg::TCMP_W-1:0]   sub_ext;
  logic [rcws_pkg::TCMP_W-1:0]   start_ext;
  logic [rcws_pkg::TCMP_W-1:0]   step_ext;

  always_comb begin
    sub_ext   = rcws_pkg::TCMP_W'(up_tok.height) << bit_pos;
    start_ext = rcws_pkg::TCMP_W'(up_tok.rem_start);
    step_ext  = rcws_pkg::TCMP_W'(up_tok.rem_step);
    tok_nxt   = up_tok;
    if (start_ext >= sub_ext) begin
      tok_nxt.rem_start = up_tok.rem_start - rcws_pkg::TNUM_W'(sub_ext);
      tok_nxt.quo_start = up_tok.quo_start | (rcws_pkg::TQ_W'(1) << bit_pos);
    end
    if (step_ext >= sub_ext) begin
      tok_nxt.rem_step = up_tok.rem_step - rcws_pkg::TSTEP_W'(sub_ext);
      tok_nxt.quo_step = up_tok.quo_step | (rcws_pkg::TQ_W'(1) << bit_pos);
    end
  end

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

FILE: rtl/core/raycast_wall_column_setup.sv
// Wall column setup: one ray request in, one wall span request out, per screen column.
//
// Channels: in_* carries one cast ray (valid/ready), out_* returns that column's wall
// span, texture face, texture column and Q.16 texture row start/step (valid/ready).
// cfg_* writes proj_plane_distance; cfg_ready is always high, write only when idle.
// Stages in order: cos, multiply, height divider, row setup, texture divider, output.
// Throughput: one request per cycle while out_ready is high.
// The two dividers are rows of restoring cells, one quotient bit per cell, and each
// request advances one cell per cycle unless the output stalls; that row length sets the latency.
// Every stage has its own valid bit and moves when it is empty or its successor moves,
// so holes close up: while out_ready is low the pipe keeps taking requests until every
// stage holds one, and only then in_ready drops. in_ready is combinational from
// out_ready through that chain.
// Reset (rst_n low, synchronous) empties all stages and sets proj_plane_distance to 554.
// The result waiting on out_* holds steady until out_ready takes it.
module raycast_wall_column_setup (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcws_pkg::PPD_W-1:0]     cfg_proj_plane_distance,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rcws_pkg::COL_W-1:0]     in_column_index,
  input  logic [rcws_pkg::DIST_W-1:0]    in_ray_distance,
  input  logic signed [rcws_pkg::ANGLE_W-1:0] in_angle_offset,
  input  logic                           in_hit_vertical,
  input  logic                           in_facing_up,
  input  logic                           in_facing_right,
  input  logic [rcws_pkg::COORD_W-1:0]   in_hit_x,
  input  logic [rcws_pkg::COORD_W-1:0]   in_hit_y,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rcws_pkg::COL_W-1:0]     out_column_out,
  output logic [rcws_pkg::HEIGHT_W-1:0]  out_wall_height,
  output logic [rcws_pkg::ROW_W-1:0]     out_top_row,
  output logic [rcws_pkg::ROW_W-1:0]     out_bottom_row,
  output logic [rcws_pkg::FACE_W-1:0]    out_texture_face,
  output logic [rcws_pkg::TCOL_W-1:0]    out_texture_column,
  output logic [rcws_pkg::TEX_W-1:0]     out_texture_row_start,
  output logic [rcws_pkg::TEX_W-1:0]     out_texture_row_step
);

  // ---------------------------------------------------------------- config
  logic [rcws_pkg::PPD_W-1:0] ppd_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppd_r <= rcws_pkg::PPD_RESET;
    end else if (cfg_valid) begin
      ppd_r <= cfg_proj_plane_distance;
    end
  end

  // ---------------------------------------------------------------- stage A
  // |angle| -> interpolated cosine, face and texture column, height numerator.
  logic                              a_vld_r;
  logic                              a_rdy;
  rcws_pkg::side_t                   a_side_r;
  rcws_pkg::side_t                   a_side_nxt;
  logic [rcws_pkg::DIST_W-1:0]       a_dist_r;
  logic [rcws_pkg::COS_W-1:0]        a_cos_r;
  logic [rcws_pkg::COS_W-1:0]        a_cos_nxt;
  logic [rcws_pkg::HNUM_W-1:0]       a_num_r;

  logic [rcws_pkg::ANGLE_W:0]        ang_mag;
  logic [rcws_pkg::COS_IDX_W-1:0]    cos_idx;
  logic [rcws_pkg::COS_IDX_W:0]      cos_idx_lo;
  logic [rcws_pkg::COS_FRAC_W-1:0]   cos_frac;
  logic [rcws_pkg::COS_W-1:0]        cos_hi;
  logic [rcws_pkg::COS_W-1:0]        cos_lo;
  logic [rcws_pkg::COS_W+rcws_pkg::COS_FRAC_W-1:0] cos_prod;
  logic [rcws_pkg::COORD_W-1:0]      tex_coord;

  always_comb begin
    // magnitude of the binary angle; -32768 maps to a half turn
    if (in_angle_offset[rcws_pkg::ANGLE_W-1]) begin
      ang_mag = (rcws_pkg::ANGLE_W+1)'(2 ** rcws_pkg::ANGLE_W) - {1'b0, in_angle_offset};
    end else begin
      ang_mag = {1'b0, in_angle_offset};
    end
    cos_idx    = ang_mag[rcws_pkg::COS_FRAC_W +: rcws_pkg::COS_IDX_W];
    cos_frac   = ang_mag[rcws_pkg::COS_FRAC_W-1:0];
    cos_idx_lo = {1'b0, cos_idx} + (rcws_pkg::COS_IDX_W+1)'(1);
    cos_hi     = rcws_pkg::COS_QUARTER[{1'b0, cos_idx}];
    cos_lo     = rcws_pkg::COS_QUARTER[cos_idx_lo];
    cos_prod   = (cos_hi - cos_lo) * cos_frac;
    // ray at or behind a quarter turn: cosine zero, height saturates downstream
    if (ang_mag >= (rcws_pkg::ANGLE_W+1)'(rcws_pkg::QUARTER)) begin
      a_cos_nxt = '0;
    end else begin
      a_cos_nxt = cos_hi - rcws_pkg::COS_W'(cos_prod >> rcws_pkg::COS_FRAC_W);
    end

    a_side_nxt.column = in_column_index;
    if (in_hit_vertical) begin
      a_side_nxt.face = in_facing_right ? rcws_pkg::FACE_EAST : rcws_pkg::FACE_WEST;
      tex_coord       = in_hit_y;
    end else begin
      a_side_nxt.face = in_facing_up ? rcws_pkg::FACE_NORTH : rcws_pkg::FACE_SOUTH;
      tex_coord       = in_hit_x;
    end
    // tile size is a power of two: modulo is the low bits of the integer part
    a_side_nxt.tcol = tex_coord[rcws_pkg::FRAC_W +: rcws_pkg::TCOL_W];
  end

  // ---------------------------------------------------------------- stage B
  // perpendicular distance = ray_distance * cos >> 15
  logic                                    b_vld_r;
  logic                                    b_rdy;
  rcws_pkg::hdiv_tok_t                     b_tok_r;
  rcws_pkg::hdiv_tok_t                     b_tok_nxt;
  logic [rcws_pkg::DIST_W+rcws_pkg::COS_W-1:0] perp_prod;

  always_comb begin
    perp_prod      = a_dist_r * a_cos_r;
    b_tok_nxt.side = a_side_r;
    b_tok_nxt.perp = rcws_pkg::DIST_W'(perp_prod >> rcws_pkg::COS_SHIFT);
    b_tok_nxt.rem  = a_num_r;
    b_tok_nxt.quo  = '0;
  end

  // ---------------------------------------------------------------- height divider
  // Cell k tests quotient bit HQ_W-1-k; the top bit flags a quotient past 16 bits
  // (which also covers a zero distance).
  rcws_pkg::hdiv_tok_t h_tok [0:rcws_pkg::HQ_W];
  logic                h_vld [0:rcws_pkg::HQ_W];
  logic                h_rdy [0:rcws_pkg::HQ_W];

  assign h_tok[0] = b_tok_r;
  assign h_vld[0] = b_vld_r;

  for (genvar k = 0; k < rcws_pkg::HQ_W; k++) begin : g_hdiv
    rcws_hdiv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bit_pos  (rcws_pkg::HPOS_W'(rcws_pkg::HQ_W - 1 - k)),
      .up_valid (h_vld[k]),
      .up_ready (h_rdy[k]),
      .up_tok   (h_tok[k]),
      .dn_valid (h_vld[k+1]),
      .dn_ready (h_rdy[k+1]),
      .dn_tok   (h_tok[k+1])
    );
  end

  // ---------------------------------------------------------------- stage M
  // saturate height, clamp rows, texture start numerator
  logic                                m_vld_r;
  logic                                m_rdy;
  rcws_pkg::tdiv_tok_t                 m_tok_r;
  rcws_pkg::tdiv_tok_t                 m_tok_nxt;
  logic [rcws_pkg::HEIGHT_W-1:0]       height;
  logic [rcws_pkg::DTOP_W-1:0]         half_h;
  logic [rcws_pkg::DTOP_W-1:0]         dtop;
  rcws_pkg::hdiv_tok_t                 h_last;

  always_comb begin
    h_last = h_tok[rcws_pkg::HQ_W];
    if (h_last.quo[rcws_pkg::HQ_W-1]) begin
      height = rcws_pkg::HEIGHT_MAX;
    end else begin
      height = h_last.quo[rcws_pkg::HEIGHT_W-1:0];
    end
    half_h = height[rcws_pkg::HEIGHT_W-1:1];

    m_tok_nxt.side   = h_last.side;
    m_tok_nxt.height = height;
    if (half_h >= rcws_pkg::DTOP_W'(rcws_pkg::HALF_ROWS)) begin
      m_tok_nxt.top = '0;
      dtop          = half_h - rcws_pkg::DTOP_W'(rcws_pkg::HALF_ROWS);
    end else begin
      m_tok_nxt.top = rcws_pkg::ROW_W'(rcws_pkg::DTOP_W'(rcws_pkg::HALF_ROWS) - half_h);
      dtop          = '0;
    end
    if (half_h >= rcws_pkg::DTOP_W'(rcws_pkg::SCREEN_HEIGHT - rcws_pkg::HALF_ROWS)) begin
      m_tok_nxt.bottom = rcws_pkg::ROW_W'(rcws_pkg::SCREEN_HEIGHT);
    end else begin
      m_tok_nxt.bottom = rcws_pkg::ROW_W'(rcws_pkg::DTOP_W'(rcws_pkg::HALF_ROWS) + half_h);
    end
    m_tok_nxt.rem_start = rcws_pkg::TNUM_W'(longint'(dtop) * rcws_pkg::TSTEP_NUM);
    m_tok_nxt.rem_step  = rcws_pkg::TSTEP_W'(rcws_pkg::TSTEP_NUM);
    m_tok_nxt.quo_start = '0;
    m_tok_nxt.quo_step  = '0;
  end

  // ---------------------------------------------------------------- texture divider
  rcws_pkg::tdiv_tok_t t_tok [0:rcws_pkg::TQ_W];
  logic                t_vld [0:rcws_pkg::TQ_W];
  logic                t_rdy [0:rcws_pkg::TQ_W];

  assign t_tok[0] = m_tok_r;
  assign t_vld[0] = m_vld_r;

  for (genvar k = 0; k < rcws_pkg::TQ_W; k++) begin : g_tdiv
    rcws_tdiv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bit_pos  (rcws_pkg::TPOS_W'(rcws_pkg::TQ_W - 1 - k)),
      .up_valid (t_vld[k]),
      .up_ready (t_rdy[k]),
      .up_tok   (t_tok[k]),
      .dn_valid (t_vld[k+1]),
      .dn_ready (t_rdy[k+1]),
      .dn_tok   (t_tok[k+1])
    );
  end

  // ---------------------------------------------------------------- output stage
  logic                            o_vld_r;
  logic                            o_rdy;
  logic [rcws_pkg::COL_W-1:0]      o_column_r;
  logic [rcws_pkg::HEIGHT_W-1:0]   o_height_r;
  logic [rcws_pkg::ROW_W-1:0]      o_top_r;
  logic [rcws_pkg::ROW_W-1:0]      o_bottom_r;
  logic [rcws_pkg::FACE_W-1:0]     o_face_r;
  logic [rcws_pkg::TCOL_W-1:0]     o_tcol_r;
  logic [rcws_pkg::TEX_W-1:0]      o_start_r;
  logic [rcws_pkg::TEX_W-1:0]      o_step_r;
  logic [rcws_pkg::TEX_W-1:0]      o_start_nxt;
  logic [rcws_pkg::TEX_W-1:0]      o_step_nxt;
  rcws_pkg::tdiv_tok_t             t_last;

  always_comb begin
    t_last = t_tok[rcws_pkg::TQ_W];
    // empty strip: no texture walk
    if (t_last.height == '0) begin
      o_start_nxt = '0;
      o_step_nxt  = '0;
    end else begin
      o_start_nxt = (t_last.quo_start > rcws_pkg::TQ_W'(rcws_pkg::TEX_MAX)) ?
                    rcws_pkg::TEX_MAX : t_last.quo_start[rcws_pkg::TEX_W-1:0];
      o_step_nxt  = (t_last.quo_step > rcws_pkg::TQ_W'(rcws_pkg::TEX_MAX)) ?
                    rcws_pkg::TEX_MAX : t_last.quo_step[rcws_pkg::TEX_W-1:0];
    end
  end

  // ---------------------------------------------------------------- flow control
  assign o_rdy                   = !o_vld_r || out_ready;
  assign t_rdy[rcws_pkg::TQ_W]   = o_rdy;
  assign m_rdy                   = !m_vld_r || t_rdy[0];
  assign h_rdy[rcws_pkg::HQ_W]   = m_rdy;
  assign b_rdy                   = !b_vld_r || h_rdy[0];
  assign a_rdy                   = !a_vld_r || b_rdy;
  assign in_ready                = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= in_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
      if (m_rdy) begin
        m_vld_r <= h_vld[rcws_pkg::HQ_W];
      end
      if (o_rdy) begin
        o_vld_r <= t_vld[rcws_pkg::TQ_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_side_r <= a_side_nxt;
      a_dist_r <= in_ray_distance;
      a_cos_r  <= a_cos_nxt;
      a_num_r  <= rcws_pkg::HNUM_W'(ppd_r * rcws_pkg::HNUM_SCALE);
    end
    if (b_rdy && a_vld_r) begin
      b_tok_r <= b_tok_nxt;
    end
    if (m_rdy && h_vld[rcws_pkg::HQ_W]) begin
      m_tok_r <= m_tok_nxt;
    end
    if (o_rdy && t_vld[rcws_pkg::TQ_W]) begin
      o_column_r <= t_last.side.column;
      o_height_r <= t_last.height;
      o_top_r    <= t_last.top;
      o_bottom_r <= t_last.bottom;
      o_face_r   <= t_last.side.face;
      o_tcol_r   <= t_last.side.tcol;
      o_start_r  <= o_start_nxt;
      o_step_r   <= o_step_nxt;
    end
  end

  assign out_valid             = o_vld_r;
  assign out_column_out        = o_column_r;
  assign out_wall_height       = o_height_r;
  assign out_top_row           = o_top_r;
  assign out_bottom_row        = o_bottom_r;
  assign out_texture_face      = o_face_r;
  assign out_texture_column    = o_tcol_r;
  assign out_texture_row_start = o_start_r;
  assign out_texture_row_step  = o_step_r;

endmodule

FILE: rtl/core/rcws_checker.sv
// Port-level checker for the wall column setup, bound to the top level.
`include "raycast_wall_column_setup_assert.svh"

module rcws_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rcws_pkg::COL_W-1:0]    out_column_out,
  input logic [rcws_pkg::HEIGHT_W-1:0] out_wall_height,
  input logic [rcws_pkg::ROW_W-1:0]    out_top_row,
  input logic [rcws_pkg::ROW_W-1:0]    out_bottom_row,
  input logic [rcws_pkg::TEX_W-1:0]    out_texture_row_start,
  input logic [rcws_pkg::TEX_W-1:0]    out_texture_row_step
);

  localparam int SUM_W = rcws_pkg::ROW_W + 1;

  // a stalled result keeps its values
  `RCWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_column_out) && $stable(out_wall_height) &&
    $stable(out_texture_row_start) && $stable(out_texture_row_step),
    "result changed while stalled")

  // strip is centered: top and bottom clamp symmetrically
  `RCWS_ASSERT_HOLDS(a_rows_centered, out_valid,
    (SUM_W'(out_top_row) + SUM_W'(out_bottom_row)) == SUM_W'(rcws_pkg::SCREEN_HEIGHT),
    "top_row and bottom_row not centered")

  // step is zero exactly for an empty strip
  `RCWS_ASSERT_HOLDS(a_empty_step, out_valid,
    (out_wall_height == '0) == (out_texture_row_step == '0),
    "texture step does not match empty strip")

  // an unclipped strip starts at texture row zero
  `RCWS_ASSERT_HOLDS(a_unclipped_start, out_valid && (out_top_row != '0),
    out_texture_row_start == '0,
    "texture start nonzero on unclipped strip")

endmodule

bind raycast_wall_column_setup rcws_checker u_rcws_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_column_out        (out_column_out),
  .out_wall_height       (out_wall_height),
  .out_top_row           (out_top_row),
  .out_bottom_row        (out_bottom_row),
  .out_texture_row_start (out_texture_row_start),
  .out_texture_row_step  (out_texture_row_step)
);
